### hdl/mlr_pkg.sv
// Shared types and constants for the midpoint line rasterizer.
// No dependencies; used by every module of the block.
`default_nettype none

package mlr_pkg;

  // Default coordinate width and the extra bits held by the signed decision terms.
  localparam int COORD_BITS_DEFAULT = 10;
  localparam int DECISION_GUARD_BITS = 4;

  // Operation codes of an input beat.
  localparam logic OP_LOAD    = 1'b0;
  localparam logic OP_ADVANCE = 1'b1;

  // Octant grouping after ordering endpoints by x.
  typedef enum logic [1:0] {
    SLOPE_SHALLOW_UP   = 2'd0,  // slope in [0,1]
    SLOPE_SHALLOW_DOWN = 2'd1,  // slope in [-1,0)
    SLOPE_STEEP_UP     = 2'd2,  // slope > 1, or vertical rising
    SLOPE_STEEP_DOWN   = 2'd3   // slope < -1, or vertical falling
  } slope_case_t;

endpackage : mlr_pkg

`default_nettype wire

### hdl/midpoint_line_rasterizer_unit.sv
// Top level of the midpoint line rasterizer: input register, line state, result register.
// Depends on mlr_pkg, mlr_line_setup and mlr_pixel_step.
`default_nettype none

// Midpoint (Bresenham) line rasterizer. Each input beat is either a load
// (operation = 0), which takes two endpoints, orders them by x, seeds the
// decision terms and returns the first pixel, or an advance (operation = 1),
// which runs one midpoint step and returns the next pixel. Exactly one result
// beat comes back per input beat; last_pixel marks the pixel at the far end,
// after which the line goes idle and an advance returns pixel_valid = 0 with
// zero coordinates. A load while a line is active drops the old line. An item
// is captured in an input register, processed by one pass through the setup
// logic (subtracts, slope compares, one add) or the step logic (one add, one
// compare) and lands in the result register once that register is empty or
// drained. Throughput is one beat per cycle while result_stall is low: the line
// state updates at the same edge a result is written, so back-to-back advances
// chain with no bubble, and the input side keeps accepting while a result
// waits only as long as the input register is empty.

module midpoint_line_rasterizer_unit #(
  parameter int COORD_BITS = mlr_pkg::COORD_BITS_DEFAULT
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  item_valid,
  output logic                       item_stall,
  input  wire logic                  operation,
  input  wire logic [COORD_BITS-1:0] first_x,
  input  wire logic [COORD_BITS-1:0] first_y,
  input  wire logic [COORD_BITS-1:0] second_x,
  input  wire logic [COORD_BITS-1:0] second_y,
  output logic                       result_valid,
  input  wire logic                  result_stall,
  output logic [COORD_BITS-1:0]      pixel_x,
  output logic [COORD_BITS-1:0]      pixel_y,
  output logic                       pixel_valid,
  output logic                       last_pixel
);
  import mlr_pkg::*;

  localparam int DW = COORD_BITS + DECISION_GUARD_BITS;

  // Input register
  logic                  held_valid;
  logic                  held_op;
  logic [COORD_BITS-1:0] held_first_x;
  logic [COORD_BITS-1:0] held_first_y;
  logic [COORD_BITS-1:0] held_second_x;
  logic [COORD_BITS-1:0] held_second_y;

  // Line state
  logic [COORD_BITS-1:0] cur_x;
  logic [COORD_BITS-1:0] cur_y;
  logic [COORD_BITS-1:0] stop_x;
  logic [COORD_BITS-1:0] stop_y;
  logic signed [DW-1:0]  decision;
  logic signed [DW-1:0]  step_inc_one;
  logic signed [DW-1:0]  step_inc_two;
  slope_case_t           slope_case;
  logic                  line_active;

  // Setup and step outputs
  logic [COORD_BITS-1:0] ld_x, ld_y, ld_stop_x, ld_stop_y;
  logic signed [DW-1:0]  ld_decision, ld_inc_one, ld_inc_two;
  slope_case_t           ld_slope;
  logic [COORD_BITS-1:0] st_x, st_y;
  logic signed [DW-1:0]  st_decision;

  // Next-state values
  logic [COORD_BITS-1:0] cur_x_next, cur_y_next, stop_x_next, stop_y_next;
  logic signed [DW-1:0]  decision_next, step_inc_one_next, step_inc_two_next;
  slope_case_t           slope_case_next;
  logic                  produce;
  logic                  last_next;

  logic out_ready;
  logic fire;

  // Result register moves when empty or drained; input register moves with it.
  assign out_ready  = !result_valid || !result_stall;
  assign fire       = held_valid && out_ready;
  assign item_stall = held_valid && !out_ready;

  mlr_line_setup #(.COORD_BITS(COORD_BITS)) u_setup (
    .first_x       (held_first_x),
    .first_y       (held_first_y),
    .second_x      (held_second_x),
    .second_y      (held_second_y),
    .start_x       (ld_x),
    .start_y       (ld_y),
    .end_x         (ld_stop_x),
    .end_y         (ld_stop_y),
    .init_decision (ld_decision),
    .init_inc_one  (ld_inc_one),
    .init_inc_two  (ld_inc_two),
    .init_slope    (ld_slope)
  );

  mlr_pixel_step #(.COORD_BITS(COORD_BITS)) u_step (
    .cur_x         (cur_x),
    .cur_y         (cur_y),
    .decision      (decision),
    .inc_one       (step_inc_one),
    .inc_two       (step_inc_two),
    .slope         (slope_case),
    .next_x        (st_x),
    .next_y        (st_y),
    .next_decision (st_decision)
  );

  always_comb begin
    cur_x_next        = cur_x;
    cur_y_next        = cur_y;
    stop_x_next       = stop_x;
    stop_y_next       = stop_y;
    decision_next     = decision;
    step_inc_one_next = step_inc_one;
    step_inc_two_next = step_inc_two;
    slope_case_next   = slope_case;
    produce           = 1'b0;
    if (held_op == OP_LOAD) begin
      cur_x_next        = ld_x;
      cur_y_next        = ld_y;
      stop_x_next       = ld_stop_x;
      stop_y_next       = ld_stop_y;
      decision_next     = ld_decision;
      step_inc_one_next = ld_inc_one;
      step_inc_two_next = ld_inc_two;
      slope_case_next   = ld_slope;
      produce           = 1'b1;
    end else if (line_active) begin
      cur_x_next    = st_x;
      cur_y_next    = st_y;
      decision_next = st_decision;
      produce       = 1'b1;
    end
  end

  // End test on the pixel about to be emitted.
  always_comb begin
    unique case (slope_case_next)
      SLOPE_SHALLOW_UP, SLOPE_SHALLOW_DOWN: last_next = !(cur_x_next < stop_x_next);
      SLOPE_STEEP_UP:                       last_next = !(cur_y_next < stop_y_next);
      default:                              last_next = !(cur_y_next > stop_y_next);
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid   <= 1'b0;
      result_valid <= 1'b0;
      line_active  <= 1'b0;
      slope_case   <= SLOPE_SHALLOW_UP;
      cur_x        <= '0;
      cur_y        <= '0;
      stop_x       <= '0;
      stop_y       <= '0;
      decision     <= '0;
      step_inc_one <= '0;
      step_inc_two <= '0;
    end else begin
      if (!item_stall) begin
        held_valid <= item_valid;
      end
      if (out_ready) begin
        result_valid <= held_valid;
      end
      if (fire && produce) begin
        cur_x        <= cur_x_next;
        cur_y        <= cur_y_next;
        stop_x       <= stop_x_next;
        stop_y       <= stop_y_next;
        decision     <= decision_next;
        step_inc_one <= step_inc_one_next;
        step_inc_two <= step_inc_two_next;
        slope_case   <= slope_case_next;
        line_active  <= !last_next;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (!item_stall && item_valid) begin
      held_op       <= operation;
      held_first_x  <= first_x;
      held_first_y  <= first_y;
      held_second_x <= second_x;
      held_second_y <= second_y;
    end
    if (fire) begin
      pixel_x     <= produce ? cur_x_next : '0;
      pixel_y     <= produce ? cur_y_next : '0;
      pixel_valid <= produce;
      last_pixel  <= produce && last_next;
    end
  end

endmodule : midpoint_line_rasterizer_unit

`default_nettype wire

### hdl/mlr_line_setup.sv
// Line setup: orders endpoints by x, classifies the slope, seeds the decision terms.
// Depends on mlr_pkg.
`default_nettype none

module mlr_line_setup #(
  parameter int COORD_BITS = mlr_pkg::COORD_BITS_DEFAULT
) (
  input  wire logic [COORD_BITS-1:0]                                  first_x,
  input  wire logic [COORD_BITS-1:0]                                  first_y,
  input  wire logic [COORD_BITS-1:0]                                  second_x,
  input  wire logic [COORD_BITS-1:0]                                  second_y,
  output logic      [COORD_BITS-1:0]                                  start_x,
  output logic      [COORD_BITS-1:0]                                  start_y,
  output logic      [COORD_BITS-1:0]                                  end_x,
  output logic      [COORD_BITS-1:0]                                  end_y,
  output logic signed [COORD_BITS+mlr_pkg::DECISION_GUARD_BITS-1:0]   init_decision,
  output logic signed [COORD_BITS+mlr_pkg::DECISION_GUARD_BITS-1:0]   init_inc_one,
  output logic signed [COORD_BITS+mlr_pkg::DECISION_GUARD_BITS-1:0]   init_inc_two,
  output mlr_pkg::slope_case_t                                        init_slope
);
  import mlr_pkg::*;

  localparam int DW  = COORD_BITS + DECISION_GUARD_BITS;
  localparam int PAD = DW - COORD_BITS;

  logic              swap;
  logic signed [DW-1:0] a_term;
  logic signed [DW-1:0] b_term;
  logic signed [DW-1:0] dy;
  logic signed [DW-1:0] neg_dy;

  assign swap    = (second_x < first_x);
  assign start_x = swap ? second_x : first_x;
  assign start_y = swap ? second_y : first_y;
  assign end_x   = swap ? first_x  : second_x;
  assign end_y   = swap ? first_y  : second_y;

  assign a_term = signed'({{PAD{1'b0}}, start_y}) - signed'({{PAD{1'b0}}, end_y});
  assign b_term = signed'({{PAD{1'b0}}, end_x}) - signed'({{PAD{1'b0}}, start_x});
  assign dy     = -a_term;
  assign neg_dy = a_term;

  always_comb begin
    priority if (b_term == '0) begin
      priority if (dy == '0)      init_slope = SLOPE_SHALLOW_UP;
      else if (dy > 0)            init_slope = SLOPE_STEEP_UP;
      else                        init_slope = SLOPE_STEEP_DOWN;
    end else if (dy >= 0 && dy <= b_term) begin
      init_slope = SLOPE_SHALLOW_UP;
    end else if (dy < 0 && neg_dy <= b_term) begin
      init_slope = SLOPE_SHALLOW_DOWN;
    end else if (dy > b_term) begin
      init_slope = SLOPE_STEEP_UP;
    end else begin
      init_slope = SLOPE_STEEP_DOWN;
    end
  end

  always_comb begin
    unique case (init_slope)
      SLOPE_SHALLOW_UP: begin
        init_decision = (a_term <<< 1) + b_term;
        init_inc_one  = a_term <<< 1;
        init_inc_two  = (a_term + b_term) <<< 1;
      end
      SLOPE_SHALLOW_DOWN: begin
        init_decision = (a_term <<< 1) - b_term;
        init_inc_one  = a_term <<< 1;
        init_inc_two  = (a_term - b_term) <<< 1;
      end
      SLOPE_STEEP_UP: begin
        init_decision = a_term + (b_term <<< 1);
        init_inc_one  = b_term <<< 1;
        init_inc_two  = (a_term + b_term) <<< 1;
      end
      default: begin
        init_decision = a_term - (b_term <<< 1);
        init_inc_one  = -(b_term <<< 1);
        init_inc_two  = (a_term - b_term) <<< 1;
      end
    endcase
  end

endmodule : mlr_line_setup

`default_nettype wire

### hdl/mlr_pixel_step.sv
// One midpoint step: picks straight or diagonal move and updates the decision.
// Depends on mlr_pkg.
`default_nettype none

module mlr_pixel_step #(
  parameter int COORD_BITS = mlr_pkg::COORD_BITS_DEFAULT
) (
  input  wire logic [COORD_BITS-1:0]                                  cur_x,
  input  wire logic [COORD_BITS-1:0]                                  cur_y,
  input  wire logic signed [COORD_BITS+mlr_pkg::DECISION_GUARD_BITS-1:0] decision,
  input  wire logic signed [COORD_BITS+mlr_pkg::DECISION_GUARD_BITS-1:0] inc_one,
  input  wire logic signed [COORD_BITS+mlr_pkg::DECISION_GUARD_BITS-1:0] inc_two,
  input  wire mlr_pkg::slope_case_t                                   slope,
  output logic      [COORD_BITS-1:0]                                  next_x,
  output logic      [COORD_BITS-1:0]                                  next_y,
  output logic signed [COORD_BITS+mlr_pkg::DECISION_GUARD_BITS-1:0]   next_decision
);
  import mlr_pkg::*;

  localparam logic [COORD_BITS-1:0] ONE = {{(COORD_BITS-1){1'b0}}, 1'b1};

  logic diag;

  // Ties go diagonal for shallow-up and steep-down, straight otherwise.
  always_comb begin
    unique case (slope)
      SLOPE_SHALLOW_UP, SLOPE_STEEP_DOWN: diag = (decision <= 0);
      default:                            diag = (decision > 0);
    endcase
  end

  always_comb begin
    next_x = cur_x;
    next_y = cur_y;
    if (diag) begin
      next_x        = cur_x + ONE;
      next_y        = (slope == SLOPE_SHALLOW_UP || slope == SLOPE_STEEP_UP) ?
                      cur_y + ONE : cur_y - ONE;
      next_decision = decision + inc_two;
    end else begin
      unique case (slope)
        SLOPE_SHALLOW_UP, SLOPE_SHALLOW_DOWN: next_x = cur_x + ONE;
        SLOPE_STEEP_UP:                       next_y = cur_y + ONE;
        default:                              next_y = cur_y - ONE;
      endcase
      next_decision = decision + inc_one;
    end
  end

endmodule : mlr_pixel_step

`default_nettype wire
